### rtl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the cubic segment flattener: coordinate and
// weight formats, segment type codes and pipeline control.
// ----------------------------------------------------------------------------
package bsf_pkg;

   localparam int COORD_W         = 24;   // Q15.8 two's complement
   localparam int WEIGHT_W        = 17;   // unsigned Q1.16, 1.0 included
   localparam int FRAC_SHIFT      = 16;
   localparam int PROD_W          = COORD_W + WEIGHT_W + 1;
   localparam int ACC_W           = PROD_W + 2;
   localparam int NUM_CTRL        = 4;    // start, ctrl a, ctrl b, end
   localparam int SAMPLES_DEFAULT = 10;

   localparam logic OP_CURVE  = 1'b0;
   localparam logic OP_CORNER = 1'b1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1) << FRAC_SHIFT;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = '0;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [WEIGHT_W-1:0]       weight_type;

   // x in the low bits so the struct packs straight onto the result word
   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

### rtl/bsf_point_pipe.sv
// ----------------------------------------------------------------------------
// bsf_point_pipe
// Two register stages: weighted products of the four control points, then
// sum, round to nearest and saturate into the result register.
// ----------------------------------------------------------------------------
module bsf_point_pipe (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  bsf_pkg::stage_ctl_type                    issue_ctl,
   input  bsf_pkg::point_type [bsf_pkg::NUM_CTRL-1:0]  pts,
   input  bsf_pkg::weight_type [bsf_pkg::NUM_CTRL-1:0] wts,
   output bsf_pkg::stage_ctl_type                    out_ctl,
   output bsf_pkg::point_type                        out_pt
);
   import bsf_pkg::*;

   localparam int Q_W = ACC_W - FRAC_SHIFT;

   logic signed [PROD_W-1:0] prod_x_in [NUM_CTRL];
   logic signed [PROD_W-1:0] prod_y_in [NUM_CTRL];
   logic signed [PROD_W-1:0] prod_x_ff [NUM_CTRL];
   logic signed [PROD_W-1:0] prod_y_ff [NUM_CTRL];
   stage_ctl_type            ctl_p_ff;
   stage_ctl_type            ctl_o_ff;
   point_type                pt_o_in;
   point_type                pt_o_ff;
   logic signed [ACC_W-1:0]  acc_x;
   logic signed [ACC_W-1:0]  acc_y;

   function automatic coord_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] rnd;
      logic signed [Q_W-1:0]   q;
      coord_type               res;
      rnd = acc + ACC_W'(1 << (FRAC_SHIFT - 1));
      q   = rnd[ACC_W-1:FRAC_SHIFT];
      // upper bits must all match the coordinate sign bit
      if (q[Q_W-1:COORD_W-1] == '0 || q[Q_W-1:COORD_W-1] == '1) begin
         res = q[COORD_W-1:0];
      end else if (q[Q_W-1]) begin
         res = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return res;
   endfunction

   always_comb begin
      for (int k = 0; k < NUM_CTRL; k++) begin
         prod_x_in[k] = $signed({1'b0, wts[k]}) * pts[k].x;
         prod_y_in[k] = $signed({1'b0, wts[k]}) * pts[k].y;
      end
   end

   always_comb begin
      acc_x = '0;
      acc_y = '0;
      for (int k = 0; k < NUM_CTRL; k++) begin
         acc_x = acc_x + ACC_W'(prod_x_ff[k]);
         acc_y = acc_y + ACC_W'(prod_y_ff[k]);
      end
      pt_o_in.x = round_sat(acc_x);
      pt_o_in.y = round_sat(acc_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
         ctl_o_ff <= '0;
      end else if (advance) begin
         ctl_p_ff <= issue_ctl;
         ctl_o_ff <= ctl_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         pt_o_ff   <= pt_o_in;
      end
   end

   assign out_ctl = ctl_o_ff;
   assign out_pt  = pt_o_ff;

endmodule

### rtl/bezier_segment_flattener.sv
// ----------------------------------------------------------------------------
// bezier_segment_flattener
// Flattens one cubic segment into sample points at t = i/N, or passes a
// corner through as its start point and vertex.
// ----------------------------------------------------------------------------
// a segment word is held in the segment holder; each point then passes the
// product and result registers. The single point datapath gives one point
// per cycle unless rsp_tready stalls: N points per curve, 2 per corner, and
// the next segment is taken in the cycle its predecessor issues its last point
// reset: synchronous, clears the segment holder and pipeline valid bits
// ----------------------------------------------------------------------------
module bezier_segment_flattener #(
   parameter int SAMPLES_PER_CURVE = bsf_pkg::SAMPLES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
   input  logic [191:0] req_tdata,
   // opcode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_x, point_y
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import bsf_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES_PER_CURVE);
   localparam logic [IDX_W-1:0] IDX_CURVE_LAST = IDX_W'(SAMPLES_PER_CURVE - 1);
   localparam logic [IDX_W-1:0] IDX_CORNER_LAST = IDX_W'(1);

   logic                          seg_valid_ff;
   logic                          seg_valid_in;
   logic                          opcode_ff;
   point_type [NUM_CTRL-1:0]      pts_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [IDX_W-1:0]              idx_in;
   logic                          advance;
   logic                          issue;
   logic                          issue_last;
   logic                          req_accept;
   stage_ctl_type                 issue_ctl;
   stage_ctl_type                 out_ctl;
   point_type                     out_pt;
   weight_type [NUM_CTRL-1:0]     wts;
   weight_type                    wtab_h [SAMPLES_PER_CURVE];
   weight_type                    wtab_a [SAMPLES_PER_CURVE];
   weight_type                    wtab_b [SAMPLES_PER_CURVE];
   weight_type                    wtab_e [SAMPLES_PER_CURVE];

   // bernstein weights, rounded to nearest, worked out at elaboration
   for (genvar gi = 0; gi < SAMPLES_PER_CURVE; gi++) begin : g_wtab
      localparam longint SI   = gi;
      localparam longint SJ   = SAMPLES_PER_CURVE - gi;
      localparam longint CUBE = longint'(SAMPLES_PER_CURVE) * SAMPLES_PER_CURVE
                                * SAMPLES_PER_CURVE;
      localparam longint W_H  = (SJ * SJ * SJ * 65536 + CUBE / 2) / CUBE;
      localparam longint W_A  = (3 * SI * SJ * SJ * 65536 + CUBE / 2) / CUBE;
      localparam longint W_B  = (3 * SI * SI * SJ * 65536 + CUBE / 2) / CUBE;
      localparam longint W_E  = (SI * SI * SI * 65536 + CUBE / 2) / CUBE;
      assign wtab_h[gi] = WEIGHT_W'(W_H);
      assign wtab_a[gi] = WEIGHT_W'(W_A);
      assign wtab_b[gi] = WEIGHT_W'(W_B);
      assign wtab_e[gi] = WEIGHT_W'(W_E);
   end

   assign advance    = !out_ctl.valid || rsp_tready;
   assign issue      = seg_valid_ff && advance;
   assign issue_last = (opcode_ff == OP_CORNER) ? (idx_ff == IDX_CORNER_LAST)
                                                : (idx_ff == IDX_CURVE_LAST);
   assign req_tready = advance && (!seg_valid_ff || issue_last);
   assign req_accept = req_tvalid && req_tready;

   assign issue_ctl.valid = issue;
   assign issue_ctl.last  = issue_last;

   // a corner is the start point, then the vertex, each at unit weight
   always_comb begin
      unique case (opcode_ff)
         OP_CORNER: begin
            wts[0] = (idx_ff == '0) ? WEIGHT_ONE : WEIGHT_ZERO;
            wts[1] = WEIGHT_ZERO;
            wts[2] = (idx_ff == '0) ? WEIGHT_ZERO : WEIGHT_ONE;
            wts[3] = WEIGHT_ZERO;
         end
         default: begin
            wts[0] = wtab_h[idx_ff];
            wts[1] = wtab_a[idx_ff];
            wts[2] = wtab_b[idx_ff];
            wts[3] = wtab_e[idx_ff];
         end
      endcase
   end

   always_comb begin
      seg_valid_in = seg_valid_ff;
      idx_in       = idx_ff;
      priority if (req_accept) begin
         seg_valid_in = 1'b1;
         idx_in       = '0;
      end else if (issue) begin
         seg_valid_in = !issue_last;
         idx_in       = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         seg_valid_ff <= seg_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         opcode_ff <= req_tuser[0];
         for (int k = 0; k < NUM_CTRL; k++) begin
            pts_ff[k].x <= req_tdata[2*COORD_W*k +: COORD_W];
            pts_ff[k].y <= req_tdata[2*COORD_W*k + COORD_W +: COORD_W];
         end
      end
   end

   bsf_point_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .issue_ctl (issue_ctl),
      .pts       (pts_ff),
      .wts       (wts),
      .out_ctl   (out_ctl),
      .out_pt    (out_pt)
   );

   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tlast  = out_ctl.last;
   assign rsp_tdata  = out_pt;

   // a new segment only replaces one that is issuing its last point
   a_accept_on_last: assert property (@(posedge clock) disable iff (reset)
      req_accept && seg_valid_ff |-> issue && issue_last)
      else $error("segment accepted while points remain");

   // sample counter never runs past the segment's last point
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      seg_valid_ff |-> (idx_ff <= IDX_CURVE_LAST) &&
                       (opcode_ff == OP_CURVE || idx_ff <= IDX_CORNER_LAST))
      else $error("sample index out of range");

   // after the last point either a fresh segment starts at zero or none is held
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      issue && issue_last |=> (!seg_valid_ff || idx_ff == '0))
      else $error("segment not closed after last point");

   // stalled output stays valid and leaves the segment holder and counter frozen
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(seg_valid_ff) &&
                                    $stable(idx_ff))
      else $error("pipeline moved under stall");

endmodule
